FILE: design/csbh_pkg.sv
// Package for the CRC string bucket hash block.
// Holds widths, reset values, register codes, the status struct and the CRC table function.
// Depends on nothing; the top level, front, back end and testbench use it.
`timescale 1ns / 1ps

package csbh_pkg;

  // Field and register widths.
  localparam int HASH_W   = 32;
  localparam int BYTE_W   = 8;
  localparam int BUCKET_W = 25;
  localparam int INDEX_W  = 24;
  localparam int CFG_IDX_W = 2;

  // Reset values of the configuration registers.
  localparam logic [HASH_W-1:0]   POLY_RESET    = 32'hAED0_0022;
  localparam logic [HASH_W-1:0]   INIT_RESET    = 32'hAED0_2022;
  localparam logic [BUCKET_W-1:0] BUCKETS_RESET = 25'd103;

  // Default depth of the queue between the hashing front and the modulo back.
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLYNOMIAL    = 2'd0,
    REG_INITIAL_VALUE = 2'd1,
    REG_BUCKET_COUNT  = 2'd2
  } cfg_reg_t;

  // Status of the modulo back end, seen by the top level.
  typedef struct packed {
    logic busy;
    logic finish;
  } back_status_t;

  // Reflected CRC table entry of one index, eight shift steps under the polynomial.
  function automatic logic [HASH_W-1:0] crc_entry(input logic [BYTE_W-1:0] idx,
                                                  input logic [HASH_W-1:0] poly);
    logic [HASH_W-1:0] v;
    v = {{(HASH_W-BYTE_W){1'b0}}, idx};
    for (int k = 0; k < BYTE_W; k++) begin
      v = v[0] ? ((v >> 1) ^ poly) : (v >> 1);
    end
    return v;
  endfunction

endpackage

FILE: design/crc_string_bucket_hash_top.sv
// Top level of the CRC string bucket hash block.
// Instantiates the hashing front, the hash queue and the modulo back end.
// Depends on csbh_pkg, csbh_front, csbh_queue and csbh_back.
`timescale 1ns / 1ps

// Usage:
// Bytes of a word enter on data_byte with last_byte marking the final one; a byte is
// taken when push is high and full is low. Each byte updates a 32-bit running hash
// through a reflected CRC table step under the configured polynomial.
// The front takes one byte per cycle while full is low. A finished word hash goes
// into a queue of QUEUE_DEPTH words; full rises only when that queue is full.
// The back end computes hash modulo bucket_count one bit per cycle: it loads the
// hash, runs 32 divide steps, then writes the result once the output is free.
// A result reaches hash_value and bucket_index through the queue and those back end
// states; the back end takes a new hash only after it has written the last result.
// A result word waits while empty is low until pop takes it; while it waits the back
// end holds its next result and the front keeps accepting bytes until the queue fills.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high, and an unknown index is ignored.
// Synchronous reset restores the register reset values, empties the queue and drops
// any partial word and any waiting result.
module crc_string_bucket_hash_top #(
  parameter int QUEUE_DEPTH = csbh_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [csbh_pkg::BYTE_W-1:0]       data_byte,
  input  logic                              last_byte,
  output logic                              empty,
  input  logic                              pop,
  output logic [csbh_pkg::HASH_W-1:0]       hash_value,
  output logic [csbh_pkg::INDEX_W-1:0]      bucket_index,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [csbh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [csbh_pkg::HASH_W-1:0]       cfg_data
);

  logic [csbh_pkg::HASH_W-1:0]   polynomial;
  logic [csbh_pkg::HASH_W-1:0]   initial_value;
  logic [csbh_pkg::BUCKET_W-1:0] bucket_count;

  logic                          in_accept;
  logic                          word_done;
  logic [csbh_pkg::HASH_W-1:0]   word_hash;
  logic [csbh_pkg::HASH_W-1:0]   q_data;
  logic                          q_pop;
  logic                          q_empty;
  logic                          q_full;
  csbh_pkg::back_status_t        back_status;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign in_accept = push && !q_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      polynomial    <= csbh_pkg::POLY_RESET;
      initial_value <= csbh_pkg::INIT_RESET;
      bucket_count  <= csbh_pkg::BUCKETS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (csbh_pkg::cfg_reg_t'(cfg_index))
        csbh_pkg::REG_POLYNOMIAL:    polynomial    <= cfg_data;
        csbh_pkg::REG_INITIAL_VALUE: initial_value <= cfg_data;
        csbh_pkg::REG_BUCKET_COUNT:  bucket_count  <= cfg_data[csbh_pkg::BUCKET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hashing front end.
  csbh_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .polynomial   (polynomial),
    .initial_value(initial_value),
    .word_done    (word_done),
    .word_hash    (word_hash)
  );

  // Queue of finished word hashes.
  csbh_queue #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(csbh_pkg::HASH_W)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (word_done),
    .wr_data(word_hash),
    .rd_en  (q_pop),
    .rd_data(q_data),
    .q_empty(q_empty),
    .q_full (q_full)
  );

  // Modulo back end with the output register.
  csbh_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .bucket_count(bucket_count),
    .pop         (pop),
    .empty       (empty),
    .hash_value  (hash_value),
    .bucket_index(bucket_index),
    .status      (back_status)
  );

`ifndef SYNTHESIS
  // The back end only takes a hash that is in the queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("back end popped an empty queue");

  // A finished word is in the queue right after its last byte.
  a_word_queued: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last_byte) |=> !q_empty)
    else $error("finished word did not reach the queue");

  // Taking a hash starts a division.
  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> back_status.busy)
    else $error("back end did not start after taking a hash");

  // A result word appears only when the back end finishes a division.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> $past(back_status.finish))
    else $error("result word appeared without a finished division");
`endif

endmodule

FILE: design/csbh_front.sv
// Front end: takes one byte per cycle while accept is high; updates the running hash.
// On the last byte of a word it hands the finished hash to the queue.
// Depends on csbh_pkg.
`timescale 1ns / 1ps

module csbh_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [csbh_pkg::BYTE_W-1:0]  data_byte,
  input  logic                         last_byte,
  input  logic [csbh_pkg::HASH_W-1:0]  polynomial,
  input  logic [csbh_pkg::HASH_W-1:0]  initial_value,
  output logic                         word_done,
  output logic [csbh_pkg::HASH_W-1:0]  word_hash
);

  logic                        word_open;
  logic [csbh_pkg::HASH_W-1:0] running_hash;
  logic [csbh_pkg::HASH_W-1:0] hash_base;
  logic [csbh_pkg::HASH_W-1:0] hash_next;

  // The first byte of a word starts from the configured initial value.
  assign hash_base = word_open ? running_hash : initial_value;

  // One table step: shift out the low byte, fold in its entry and the new data byte.
  assign hash_next = (hash_base >> csbh_pkg::BYTE_W)
                   ^ csbh_pkg::crc_entry(hash_base[csbh_pkg::BYTE_W-1:0], polynomial)
                   ^ {data_byte, {(csbh_pkg::HASH_W-csbh_pkg::BYTE_W){1'b0}}};

  assign word_done = accept && last_byte;
  assign word_hash = hash_next;

  // Word tracking; the running hash itself needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_open <= 1'b0;
    end else if (accept) begin
      word_open <= !last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !last_byte) begin
      running_hash <= hash_next;
    end
  end

endmodule

FILE: design/csbh_queue.sv
// Short queue of finished word hashes between the front and the back end.
// Register storage with one write and one read place, first in first out.
// Depends on csbh_pkg for the default depth only through the top level.
`timescale 1ns / 1ps

module csbh_queue #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             q_empty,
  output logic             q_full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign q_empty = (count == '0);
  assign q_full  = (count == CNT_W'(DEPTH));
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = entries[rd_ptr];

  // Pointers wrap at the queue depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage holds payload only.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: design/csbh_back.sv
// Modulo back end: takes one hash from the queue, finds its remainder by the
// bucket count one quotient bit per cycle, and holds the result word for the receiver.
// Depends on csbh_pkg.
`timescale 1ns / 1ps

module csbh_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  logic [csbh_pkg::HASH_W-1:0]    q_data,
  output logic                           q_pop,
  input  logic [csbh_pkg::BUCKET_W-1:0]  bucket_count,
  input  logic                           pop,
  output logic                           empty,
  output logic [csbh_pkg::HASH_W-1:0]    hash_value,
  output logic [csbh_pkg::INDEX_W-1:0]   bucket_index,
  output csbh_pkg::back_status_t         status
);

  localparam int CNT_W = $clog2(csbh_pkg::HASH_W);
  localparam int REM_W = csbh_pkg::BUCKET_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t                        state;
  logic [CNT_W-1:0]              cnt;
  logic [csbh_pkg::HASH_W-1:0]   word_hash;
  logic [csbh_pkg::HASH_W-1:0]   dividend;
  logic [REM_W-1:0]              rem;
  logic [REM_W-1:0]              trial;
  logic [REM_W-1:0]              rem_next;
  logic                          out_valid;
  logic                          finish;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  assign trial    = {rem[REM_W-2:0], dividend[csbh_pkg::HASH_W-1]};
  assign rem_next = (trial >= {1'b0, bucket_count}) ? (trial - {1'b0, bucket_count}) : trial;

  assign q_pop  = (state == S_IDLE) && !q_empty;
  assign finish = (state == S_DONE) && (!out_valid || pop);
  assign empty  = !out_valid;

  assign status.busy   = (state != S_IDLE);
  assign status.finish = finish;

  // Divider sequencer and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // A new result replaces the one taken in the same cycle.
      if (finish) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            word_hash <= q_data;
            dividend  <= q_data;
            rem       <= '0;
            cnt       <= '0;
            state     <= S_RUN;
          end
        end
        S_RUN: begin
          rem      <= rem_next;
          dividend <= dividend << 1;
          cnt      <= cnt + 1'b1;
          if (cnt == CNT_W'(csbh_pkg::HASH_W - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (finish) begin
            hash_value   <= word_hash;
            bucket_index <= (bucket_count == '0) ? '0 : rem[csbh_pkg::INDEX_W-1:0];
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for crc_string_bucket_hash_top.
// Streams words byte by byte, writes the registers between phases, predicts hash and bucket.
// Depends on csbh_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;

  // Index past the register list; a write to it must change nothing.
  localparam logic [csbh_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 6;
  localparam int PHASE_BYTES   = 270;

  typedef struct packed {
    logic [csbh_pkg::HASH_W-1:0]  hash;
    logic [csbh_pkg::INDEX_W-1:0] bucket;
  } hash_result_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    logic [csbh_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [csbh_pkg::HASH_W-1:0]    value;
    logic                           last;
    bit                             typed;
    hash_result_t                   want;
  } stim_row_t;

  logic                           clk;
  logic                           rst;
  logic                           push;
  logic                           full;
  logic [csbh_pkg::BYTE_W-1:0]    data_byte;
  logic                           last_byte;
  logic                           empty;
  logic                           pop;
  logic [csbh_pkg::HASH_W-1:0]    hash_value;
  logic [csbh_pkg::INDEX_W-1:0]   bucket_index;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [csbh_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [csbh_pkg::HASH_W-1:0]    cfg_data;

  // Predictor state: its own copy of the registers and the running hash.
  logic [csbh_pkg::HASH_W-1:0]   poly_q;
  logic [csbh_pkg::HASH_W-1:0]   init_q;
  logic [csbh_pkg::BUCKET_W-1:0] buckets_q;
  logic [csbh_pkg::HASH_W-1:0]   run_q;
  bit                            word_open_q;

  hash_result_t expected_hashes[$];
  stim_row_t    directed_rows[$];

  int  errors;
  int  cycles;
  int  bytes_sent;
  int  words_sent;
  int  reg_writes;
  int  full_stalls;
  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  quiet;
  bit  hold_req;
  bit  dirty;

  crc_string_bucket_hash_top u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .empty        (empty),
    .pop          (pop),
    .hash_value   (hash_value),
    .bucket_index (bucket_index),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Free-running clock, 20 ns period.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cycle count and the hard stop.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycles,
               expected_hashes.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0d: %s", cycles, msg);
    errors++;
  endtask

  // Table entry: eight reflected shift steps of the index under the polynomial.
  function automatic logic [csbh_pkg::HASH_W-1:0] crc_byte_entry(
      input logic [csbh_pkg::BYTE_W-1:0] idx,
      input logic [csbh_pkg::HASH_W-1:0] poly);
    logic [csbh_pkg::HASH_W-1:0] v;
    v = csbh_pkg::HASH_W'(idx);
    repeat (csbh_pkg::BYTE_W) begin
      if (v[0]) v = (v >> 1) ^ poly;
      else      v = v >> 1;
    end
    return v;
  endfunction

  // Register write as the block sees it; an unknown index is dropped.
  function automatic void apply_reg_write(input logic [csbh_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [csbh_pkg::HASH_W-1:0] val);
    case (idx)
      csbh_pkg::REG_POLYNOMIAL:    poly_q = val;
      csbh_pkg::REG_INITIAL_VALUE: init_q = val;
      csbh_pkg::REG_BUCKET_COUNT:  buckets_q = val[csbh_pkg::BUCKET_W-1:0];
      default: ;
    endcase
  endfunction

  // One byte through the hash; a last byte yields the word hash and its bucket.
  function automatic bit hash_predict(input logic [csbh_pkg::BYTE_W-1:0] b, input logic lb,
                                      output hash_result_t res);
    logic [csbh_pkg::HASH_W-1:0] h;
    logic [csbh_pkg::HASH_W-1:0] rem;
    h = word_open_q ? run_q : init_q;
    h = (h >> 8) ^ crc_byte_entry(h[csbh_pkg::BYTE_W-1:0], poly_q) ^ {b, 24'd0};
    res = '0;
    if (!lb) begin
      run_q = h;
      word_open_q = 1'b1;
      return 1'b0;
    end
    rem = (buckets_q == '0) ? '0 : h % csbh_pkg::HASH_W'(buckets_q);
    res.hash = h;
    res.bucket = rem[csbh_pkg::INDEX_W-1:0];
    run_q = init_q;
    word_open_q = 1'b0;
    return 1'b1;
  endfunction

  // Offer one byte and wait until the block takes it.
  task automatic send_byte(input logic [csbh_pkg::BYTE_W-1:0] b, input logic lb,
                           input bit typed, input hash_result_t want);
    hash_result_t res;
    bit produced;
    @(negedge clk);
    push <= 1'b1;
    data_byte <= b;
    last_byte <= lb;
    @(posedge clk);
    while (full) begin
      full_stalls++;
      @(posedge clk);
    end
    bytes_sent++;
    dirty = 1'b1;
    produced = hash_predict(b, lb, res);
    if (produced) begin
      words_sent++;
      expected_hashes.push_back(typed ? want : res);
    end
  endtask

  task automatic idle_sender(input int n);
    @(negedge clk);
    push <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Drain every expected word, then give the front time to go quiet.
  task automatic settle();
    if (dirty) begin
      @(negedge clk);
      push <= 1'b0;
      while (expected_hashes.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      dirty = 1'b0;
    end
  endtask

  task automatic write_reg(input logic [csbh_pkg::CFG_IDX_W-1:0] idx,
                           input logic [csbh_pkg::HASH_W-1:0] val);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg_write(idx, val);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic stim_row_t row_byte(input logic [csbh_pkg::BYTE_W-1:0] b,
                                         input logic lb);
    stim_row_t r;
    r = '{ROW_BYTE, csbh_pkg::REG_POLYNOMIAL, csbh_pkg::HASH_W'(b), lb, 1'b0, '0};
    return r;
  endfunction

  function automatic stim_row_t row_fixed(input logic [csbh_pkg::BYTE_W-1:0] b,
                                          input logic lb,
                                          input logic [csbh_pkg::HASH_W-1:0] h,
                                          input logic [csbh_pkg::INDEX_W-1:0] bkt);
    stim_row_t r;
    r = '{ROW_BYTE, csbh_pkg::REG_POLYNOMIAL, csbh_pkg::HASH_W'(b), lb, 1'b1, '{h, bkt}};
    return r;
  endfunction

  function automatic stim_row_t row_cfg(input logic [csbh_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [csbh_pkg::HASH_W-1:0] val);
    stim_row_t r;
    r = '{ROW_CFG, idx, val, 1'b0, 1'b0, '0};
    return r;
  endfunction

  // Directed table. With a zero polynomial and zero start value a byte just lands in
  // the top of the hash, so those rows carry their expected words directly.
  task automatic build_directed();
    // Reset settings, single bytes at both extremes and a short word.
    directed_rows.push_back(row_byte(8'h00, 1'b1));
    directed_rows.push_back(row_byte(8'hFF, 1'b1));
    directed_rows.push_back(row_byte(8'h41, 1'b0));
    directed_rows.push_back(row_byte(8'h42, 1'b0));
    directed_rows.push_back(row_byte(8'h43, 1'b1));
    // All-zero registers; a zero bucket count gives bucket zero.
    directed_rows.push_back(row_cfg(csbh_pkg::REG_POLYNOMIAL, 32'h0000_0000));
    directed_rows.push_back(row_cfg(csbh_pkg::REG_INITIAL_VALUE, 32'h0000_0000));
    directed_rows.push_back(row_cfg(csbh_pkg::REG_BUCKET_COUNT, 32'h0000_0000));
    directed_rows.push_back(row_fixed(8'hFF, 1'b1, 32'hFF00_0000, 24'h0));
    directed_rows.push_back(row_fixed(8'h00, 1'b1, 32'h0000_0000, 24'h0));
    directed_rows.push_back(row_byte(8'h12, 1'b0));
    directed_rows.push_back(row_fixed(8'h34, 1'b1, 32'h3412_0000, 24'h0));
    // Largest bucket count: the remainder exceeds 24 bits and is truncated.
    directed_rows.push_back(row_cfg(csbh_pkg::REG_BUCKET_COUNT, 32'h01FF_FFFF));
    directed_rows.push_back(row_fixed(8'hFF, 1'b1, 32'hFF00_0000, 24'h00_007F));
    // Smallest nonzero bucket count, then a write to an unknown index.
    directed_rows.push_back(row_cfg(csbh_pkg::REG_BUCKET_COUNT, 32'h0000_0001));
    directed_rows.push_back(row_fixed(8'h80, 1'b1, 32'h8000_0000, 24'h0));
    directed_rows.push_back(row_cfg(REG_UNUSED, 32'hFFFF_FFFF));
    directed_rows.push_back(row_fixed(8'h01, 1'b1, 32'h0100_0000, 24'h0));
    // All-ones registers and a bucket count of exactly 2^24.
    directed_rows.push_back(row_cfg(csbh_pkg::REG_POLYNOMIAL, 32'hFFFF_FFFF));
    directed_rows.push_back(row_cfg(csbh_pkg::REG_INITIAL_VALUE, 32'hFFFF_FFFF));
    directed_rows.push_back(row_cfg(csbh_pkg::REG_BUCKET_COUNT, 32'h0100_0000));
    directed_rows.push_back(row_byte(8'hFF, 1'b0));
    directed_rows.push_back(row_byte(8'h00, 1'b0));
    directed_rows.push_back(row_byte(8'h5A, 1'b1));
    // A start-value write in the middle of a word only affects the next word.
    directed_rows.push_back(row_byte(8'h12, 1'b0));
    directed_rows.push_back(row_cfg(csbh_pkg::REG_INITIAL_VALUE, 32'h0000_0000));
    directed_rows.push_back(row_byte(8'h34, 1'b1));
    directed_rows.push_back(row_byte(8'h56, 1'b1));
  endtask

  function automatic logic [csbh_pkg::HASH_W-1:0] pick_buckets();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'h01FF_FFFF;
      2:       return 32'h0100_0000 + $urandom_range(0, 32'h00FF_FFFF);
      3:       return {7'd0, 25'($urandom)};
      4:       return $urandom_range(1, 65536);
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  // Stimulus: reset, directed table, random phases, then the final drain.
  initial begin
    stim_row_t r;
    int len;
    int phase_bytes;
    logic [csbh_pkg::BYTE_W-1:0] b;

    rst = 1'b1;
    push = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = csbh_pkg::REG_POLYNOMIAL;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    dirty = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 15;
    poly_q = csbh_pkg::POLY_RESET;
    init_q = csbh_pkg::INIT_RESET;
    buckets_q = csbh_pkg::BUCKETS_RESET;
    run_q = csbh_pkg::INIT_RESET;
    word_open_q = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    build_directed();
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.kind == ROW_CFG) begin
        write_reg(r.reg_idx, r.value);
      end else begin
        send_byte(r.value[csbh_pkg::BYTE_W-1:0], r.last, r.typed, r.want);
        if ($urandom_range(0, 99) < 30) idle_sender($urandom_range(1, 6));
      end
    end

    // Random phases: fresh registers each time, then words of random bytes.
    for (int p = 0; p < PHASES; p++) begin
      write_reg(csbh_pkg::REG_BUCKET_COUNT, pick_buckets());
      write_reg(csbh_pkg::REG_POLYNOMIAL,
                ($urandom_range(0, 3) == 0) ? 32'hEDB8_8320 : $urandom);
      if ($urandom_range(0, 1)) write_reg(REG_UNUSED, $urandom);
      write_reg(csbh_pkg::REG_INITIAL_VALUE, $urandom);

      if (p == PHASES - 1) begin
        quiet = 1'b1;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       tx_idle_pct = 0;
          1:       tx_idle_pct = 15;
          default: tx_idle_pct = 40;
        endcase
        rx_idle_pct = (p == 0) ? 0 : $urandom_range(0, 40);
      end

      // Back pressure: the receiver stops while single-byte words keep coming.
      if (p == 1) begin
        hold_req = 1'b1;
        repeat (40) send_byte(csbh_pkg::BYTE_W'($urandom), 1'b1, 1'b0, '0);
      end

      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          b = csbh_pkg::BYTE_W'($urandom);
          send_byte(b, k == len - 1, 1'b0, '0);
          phase_bytes++;
          if (!quiet && $urandom_range(0, 99) < tx_idle_pct)
            idle_sender($urandom_range(1, 6));
        end
      end
    end

    // Wait out every expected word, then a quiet tail for stray results.
    @(negedge clk);
    push <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Hashed %0d bytes into %0d words over %0d register writes and several settings.",
             bytes_sent, words_sent, reg_writes);
    $display("Input held off by a full queue for %0d cycles; %0d mismatches.",
             full_stalls, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver: random pop bursts, one long hold-off, and a check of each word taken.
  initial begin
    int gap;
    hash_result_t exp_res;
    gap = 0;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (gap > 0) begin
        pop <= 1'b0;
        gap--;
      end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
        pop <= 1'b0;
        gap = $urandom_range(1, 6) - 1;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk);
      if (pop && !empty) begin
        if (expected_hashes.size() == 0) begin
          report_mismatch($sformatf("unexpected word hash %08h bucket %06h",
                                    hash_value, bucket_index));
        end else begin
          exp_res = expected_hashes.pop_front();
          if (hash_value !== exp_res.hash)
            report_mismatch($sformatf("hash_value %08h, expected %08h",
                                      hash_value, exp_res.hash));
          if (bucket_index !== exp_res.bucket)
            report_mismatch($sformatf("bucket_index %06h, expected %06h (hash %08h)",
                                      bucket_index, exp_res.bucket, exp_res.hash));
        end
      end
      @(negedge clk);
    end
  end

endmodule

FILE: sim.f
design/csbh_pkg.sv
design/csbh_front.sv
design/csbh_queue.sv
design/csbh_back.sv
design/crc_string_bucket_hash_top.sv
tb/testbench.sv
